>>> design/sts_pkg.sv
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types, register codes and song/effect tables for the tone synth.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int ADDR_W     = 3;
  localparam int SONG_STEPS = 48;
  localparam int STEP_MS    = 115;

  localparam logic [0:0] REG_SOUND_ENABLED = 1'b0;
  localparam logic [0:0] REG_SONG_SEL      = 1'b1;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_EVENT = 1'b1;

  localparam logic [10:0] MEL_WEIGHT  = 11'd1802;
  localparam logic [10:0] BASS_WEIGHT = 11'd1475;
  localparam logic [14:0] CLAMP_LIMIT = 15'd29491;

  // song tables, three songs of 16 steps, frequencies in centihertz
  localparam logic [16:0] SONG_MEL [SONG_STEPS] = '{
    17'd32963, 17'd39200, 17'd49388, 17'd39200, 17'd34923, 17'd44000, 17'd52325, 17'd44000,
    17'd39200, 17'd49388, 17'd58733, 17'd49388, 17'd34923, 17'd44000, 17'd32963, 17'd26163,
    17'd26163, 17'd29366, 17'd31113, 17'd39200, 17'd36999, 17'd31113, 17'd29366, 17'd34923,
    17'd44000, 17'd34923, 17'd32963, 17'd39200, 17'd49388, 17'd39200, 17'd29366, 17'd24694,
    17'd22000, 17'd27718, 17'd32963, 17'd41530, 17'd39200, 17'd32963, 17'd27718, 17'd24694,
    17'd29366, 17'd36999, 17'd44000, 17'd55437, 17'd49388, 17'd44000, 17'd36999, 17'd22000
  };

  localparam logic [16:0] SONG_BASS [SONG_STEPS] = '{
    17'd8241,  17'd8241,  17'd9800,  17'd9800,  17'd8731,  17'd8731,  17'd11000, 17'd11000,
    17'd9800,  17'd9800,  17'd12347, 17'd12347, 17'd8731,  17'd8731,  17'd8241,  17'd6541,
    17'd6541,  17'd6541,  17'd7778,  17'd7778,  17'd7342,  17'd7342,  17'd6541,  17'd6541,
    17'd8731,  17'd8731,  17'd8241,  17'd8241,  17'd9800,  17'd9800,  17'd7342,  17'd6174,
    17'd5500,  17'd6930,  17'd8241,  17'd10383, 17'd9800,  17'd8241,  17'd6930,  17'd6174,
    17'd7342,  17'd9250,  17'd11000, 17'd13859, 17'd12347, 17'd11000, 17'd9250,  17'd5500
  };

  localparam logic [2:0] SONG_TICKS [SONG_STEPS] = '{
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd4,
    3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd4,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd4
  };

  // effect tones, indexed by event bit number
  localparam logic [16:0] TONE_FREQ [8] = '{
    17'd11500, 17'd19000, 17'd7500, 17'd33000, 17'd52200, 17'd66000, 17'd5500, 17'd88000
  };
  localparam logic [8:0] TONE_MS [8] = '{
    9'd20, 9'd30, 9'd45, 9'd110, 9'd180, 9'd180, 9'd500, 9'd420
  };
  localparam logic [15:0] TONE_VOL [8] = '{
    16'd1638, 16'd2621, 16'd3277, 16'd3932, 16'd4588, 16'd3932, 16'd5898, 16'd4260
  };

  typedef struct packed {
    logic        mel_on;
    logic        mel_high;
    logic        bass_on;
    logic [14:0] tri_p;
    logic        eff_on;
    logic        eff_high;
    logic [15:0] eff_vol;
  } mix_in_t;

endpackage

>>> design/sts_tables.sv
// ----------------------------------------------------------------------------
// sts_tables
// Song step and effect tone lookup: phase increments and lengths in samples.
// ----------------------------------------------------------------------------
module sts_tables #(
  parameter int FS_HZ      = 48000,
  parameter int PHASE_BITS = 24
) (
  input  logic [1:0]            track,
  input  logic [3:0]            step,
  input  logic [2:0]            tone,
  output logic [PHASE_BITS-1:0] mel_inc,
  output logic [PHASE_BITS-1:0] bass_inc,
  output logic [15:0]           note_len,
  output logic [PHASE_BITS-1:0] eff_inc,
  output logic [15:0]           eff_len,
  output logic [15:0]           eff_vol
);

  function automatic logic [PHASE_BITS-1:0] freq_to_inc(input logic [16:0] centihz);
    logic [63:0] num;
    num = ({47'd0, centihz} << PHASE_BITS) + 64'(50 * FS_HZ);
    num = num / 64'(100 * FS_HZ);
    return num[PHASE_BITS-1:0];
  endfunction

  function automatic logic [15:0] note_len_of(input logic [2:0] ticks);
    logic [63:0] n;
    n = 64'(FS_HZ) * 64'(sts_pkg::STEP_MS) * {61'd0, ticks};
    n = n / 64'd1000;
    return n[15:0];
  endfunction

  function automatic logic [15:0] eff_len_of(input logic [8:0] ms);
    logic [63:0] n;
    n = 64'(FS_HZ) * {55'd0, ms};
    n = n / 64'd1000;
    return n[15:0];
  endfunction

  logic [PHASE_BITS-1:0] mel_tab  [64];
  logic [PHASE_BITS-1:0] bass_tab [64];
  logic [15:0]           len_tab  [64];
  logic [PHASE_BITS-1:0] einc_tab [8];
  logic [15:0]           elen_tab [8];

  for (genvar i = 0; i < 64; i++) begin : g_song
    if (i < sts_pkg::SONG_STEPS) begin : g_real
      assign mel_tab[i]  = freq_to_inc(sts_pkg::SONG_MEL[i]);
      assign bass_tab[i] = freq_to_inc(sts_pkg::SONG_BASS[i]);
      assign len_tab[i]  = note_len_of(sts_pkg::SONG_TICKS[i]);
    end else begin : g_none
      // track three has no song
      assign mel_tab[i]  = '0;
      assign bass_tab[i] = '0;
      assign len_tab[i]  = '0;
    end
  end

  for (genvar j = 0; j < 8; j++) begin : g_tone
    assign einc_tab[j] = freq_to_inc(sts_pkg::TONE_FREQ[j]);
    assign elen_tab[j] = eff_len_of(sts_pkg::TONE_MS[j]);
  end

  assign mel_inc  = mel_tab[{track, step}];
  assign bass_inc = bass_tab[{track, step}];
  assign note_len = len_tab[{track, step}];
  assign eff_inc  = einc_tab[tone];
  assign eff_len  = elen_tab[tone];
  assign eff_vol  = sts_pkg::TONE_VOL[tone];

endmodule

>>> design/sts_mixer.sv
// ----------------------------------------------------------------------------
// sts_mixer
// Weights the three voices in Q2.30, rounds half up to Q1.15 and clamps.
// ----------------------------------------------------------------------------
module sts_mixer (
  input  sts_pkg::mix_in_t mix,
  output logic [15:0]      sample
);

  logic signed [31:0] mel_term;
  logic signed [18:0] tri_v;
  logic signed [31:0] tri_ext;
  logic signed [31:0] bass_term;
  logic signed [31:0] eff_mag;
  logic signed [31:0] eff_term;
  logic signed [31:0] acc;
  logic signed [31:0] rnd;
  logic signed [31:0] lim;

  assign lim = $signed({17'd0, sts_pkg::CLAMP_LIMIT});

  always_comb begin
    mel_term = '0;
    if (mix.mel_on) begin
      mel_term = mix.mel_high ? $signed({6'd0, sts_pkg::MEL_WEIGHT, 15'd0})
                              : -$signed({6'd0, sts_pkg::MEL_WEIGHT, 15'd0});
    end
  end

  always_comb begin
    if (mix.tri_p[14]) begin
      tri_v = 19'sd98304 - $signed({2'b00, mix.tri_p, 2'b00});
    end else begin
      tri_v = $signed({2'b00, mix.tri_p, 2'b00}) - 19'sd32768;
    end
    tri_ext   = {{13{tri_v[18]}}, tri_v};
    bass_term = mix.bass_on ? tri_ext * $signed({21'd0, sts_pkg::BASS_WEIGHT}) : '0;
  end

  always_comb begin
    eff_mag  = $signed({1'b0, mix.eff_vol, 15'd0});
    eff_term = mix.eff_on ? (mix.eff_high ? eff_mag : -eff_mag) : '0;
  end

  always_comb begin
    acc = mel_term + bass_term + eff_term;
    rnd = (acc + 32'sd16384) >>> 15;
    if (rnd > lim) begin
      sample = lim[15:0];
    end else if (rnd < -lim) begin
      sample = 16'(-lim);
    end else begin
      sample = rnd[15:0];
    end
  end

endmodule

>>> design/square_triangle_tone_synth.sv
// ----------------------------------------------------------------------------
// square_triangle_tone_synth
// Two-voice sequenced tone synth with a triggered square-wave effect voice.
//
//   channel | dir | handshake          | payload
//   s_*     | in  | s_tvalid/s_tready  | s_tuser mode, s_tdata event_bits
//   m_*     | out | m_tvalid/m_tready  | m_tdata sample_out (Q1.15)
//   apb     | in  | psel/penable/pready| 0x0 sound_enabled, 0x4 song_sel
//
// One item per cycle; a tick's sample enters the result register as the
// tick leaves the input register. An event transaction gives no sample.
// With the result register full and m_tready low, a tick waits in the input
// register and s_tready drops; events are taken while no tick waits.
// Reset restores sound on, track 0 and all voices idle.
// ----------------------------------------------------------------------------
module square_triangle_tone_synth #(
  parameter int FS_HZ      = 48000,
  parameter int PHASE_BITS = 24
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [7:0]                 s_tdata,   // [7:0] event_bits
  input  logic                       s_tuser,   // [0] mode
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [15:0]                m_tdata,   // [15:0] sample_out
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [sts_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // input register
  logic       r_valid;
  logic       r_mode;
  logic [7:0] r_event;

  // architectural state
  logic                  sound_enabled, sound_enabled_next;
  logic [2:0]            song_sel, song_sel_next;
  logic [3:0]            seq_step, seq_step_next;
  logic [15:0]           note_samples_left, note_samples_left_next;
  logic [PHASE_BITS-1:0] melody_increment, melody_increment_next;
  logic [PHASE_BITS-1:0] bass_increment, bass_increment_next;
  logic [PHASE_BITS-1:0] melody_phase, melody_phase_next;
  logic [PHASE_BITS-1:0] bass_phase, bass_phase_next;
  logic [PHASE_BITS-1:0] effect_increment, effect_increment_next;
  logic [PHASE_BITS-1:0] effect_phase, effect_phase_next;
  logic [15:0]           effect_samples_left, effect_samples_left_next;
  logic [15:0]           effect_volume, effect_volume_next;

  logic [15:0] out_data;
  logic        out_valid;

  logic       cfg_wr;
  logic [0:0] reg_index;
  logic       proc_tick, proc_event, proc;
  logic       music_on, load;
  logic [2:0] tone_sel;

  logic [PHASE_BITS-1:0] tab_mel_inc, tab_bass_inc, tab_eff_inc;
  logic [15:0]           tab_note_len, tab_eff_len, tab_eff_vol;
  logic [PHASE_BITS-1:0] mel_inc_cur, bass_inc_cur;
  logic [15:0]           note_cur;
  logic                  mel_on, bass_on, eff_on;

  sts_pkg::mix_in_t mix;
  logic [15:0]      mix_sample;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite & pready;
  assign reg_index = paddr[2];

  always_comb begin
    unique case (reg_index)
      sts_pkg::REG_SOUND_ENABLED: prdata = {31'd0, sound_enabled};
      sts_pkg::REG_SONG_SEL:      prdata = {29'd0, song_sel};
      default:                    prdata = '0;
    endcase
  end

  // handshake
  assign proc_tick  = r_valid && (r_mode == sts_pkg::MODE_TICK) && (!out_valid || m_tready);
  assign proc_event = r_valid && (r_mode == sts_pkg::MODE_EVENT);
  assign proc       = proc_tick || proc_event;
  assign s_tready   = !r_valid || proc;
  assign m_tvalid   = out_valid;
  assign m_tdata    = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      r_valid <= 1'b1;
    end else if (proc) begin
      r_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      r_mode  <= s_tuser;
      r_event <= s_tdata;
    end
  end

  // highest set event bit wins
  always_comb begin
    tone_sel = '0;
    for (int b = 1; b < 8; b++) begin
      if (r_event[b]) tone_sel = 3'(b);
    end
  end

  sts_tables #(
    .FS_HZ      (FS_HZ),
    .PHASE_BITS (PHASE_BITS)
  ) u_tables (
    .track    (song_sel[1:0]),
    .step     (seq_step),
    .tone     (tone_sel),
    .mel_inc  (tab_mel_inc),
    .bass_inc (tab_bass_inc),
    .note_len (tab_note_len),
    .eff_inc  (tab_eff_inc),
    .eff_len  (tab_eff_len),
    .eff_vol  (tab_eff_vol)
  );

  assign music_on     = !song_sel[2];
  assign load         = music_on && (note_samples_left == '0);
  assign mel_inc_cur  = load ? tab_mel_inc  : melody_increment;
  assign bass_inc_cur = load ? tab_bass_inc : bass_increment;
  assign note_cur     = load ? tab_note_len : note_samples_left;
  assign mel_on       = sound_enabled && music_on && (mel_inc_cur != '0);
  assign bass_on      = sound_enabled && music_on && (bass_inc_cur != '0);
  assign eff_on       = sound_enabled && (effect_samples_left != '0) && (effect_increment != '0);

  always_comb begin
    mix.mel_on   = mel_on;
    mix.mel_high = !melody_phase[PHASE_BITS-1];
    mix.bass_on  = bass_on;
    mix.tri_p    = bass_phase[PHASE_BITS-1 -: 15];
    mix.eff_on   = eff_on;
    mix.eff_high = !effect_phase[PHASE_BITS-1];
    mix.eff_vol  = effect_volume;
  end

  sts_mixer u_mixer (
    .mix    (mix),
    .sample (mix_sample)
  );

  always_comb begin
    sound_enabled_next       = sound_enabled;
    song_sel_next            = song_sel;
    seq_step_next            = seq_step;
    note_samples_left_next   = note_samples_left;
    melody_increment_next    = melody_increment;
    bass_increment_next      = bass_increment;
    melody_phase_next        = melody_phase;
    bass_phase_next          = bass_phase;
    effect_increment_next    = effect_increment;
    effect_phase_next        = effect_phase;
    effect_samples_left_next = effect_samples_left;
    effect_volume_next       = effect_volume;

    if (proc_tick && sound_enabled) begin
      if (music_on) begin
        if (load) begin
          melody_increment_next = tab_mel_inc;
          bass_increment_next   = tab_bass_inc;
          if (song_sel[1:0] != 2'd3) seq_step_next = seq_step + 4'd1;
        end
        if (mel_on)  melody_phase_next = melody_phase + mel_inc_cur;
        if (bass_on) bass_phase_next   = bass_phase + bass_inc_cur;
        note_samples_left_next = (note_cur != '0) ? note_cur - 16'd1 : note_cur;
      end
      if (eff_on) begin
        effect_phase_next        = effect_phase + effect_increment;
        effect_samples_left_next = effect_samples_left - 16'd1;
      end
    end

    if (proc_event && sound_enabled && (r_event != '0)) begin
      effect_increment_next    = tab_eff_inc;
      effect_samples_left_next = tab_eff_len;
      effect_volume_next       = tab_eff_vol;
      effect_phase_next        = '0;
    end

    if (cfg_wr) begin
      unique case (reg_index)
        sts_pkg::REG_SOUND_ENABLED: begin
          sound_enabled_next = pwdata[0];
          if (!pwdata[0]) effect_samples_left_next = '0;
        end
        sts_pkg::REG_SONG_SEL: begin
          song_sel_next          = pwdata[2:0];
          seq_step_next          = '0;
          note_samples_left_next = '0;
          melody_phase_next      = '0;
          bass_phase_next        = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sound_enabled       <= 1'b1;
      song_sel            <= '0;
      seq_step            <= '0;
      note_samples_left   <= '0;
      melody_increment    <= '0;
      bass_increment      <= '0;
      melody_phase        <= '0;
      bass_phase          <= '0;
      effect_increment    <= '0;
      effect_phase        <= '0;
      effect_samples_left <= '0;
      effect_volume       <= '0;
    end else begin
      sound_enabled       <= sound_enabled_next;
      song_sel            <= song_sel_next;
      seq_step            <= seq_step_next;
      note_samples_left   <= note_samples_left_next;
      melody_increment    <= melody_increment_next;
      bass_increment      <= bass_increment_next;
      melody_phase        <= melody_phase_next;
      bass_phase          <= bass_phase_next;
      effect_increment    <= effect_increment_next;
      effect_phase        <= effect_phase_next;
      effect_samples_left <= effect_samples_left_next;
      effect_volume       <= effect_volume_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (proc_tick) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_tick) out_data <= mix_sample;
  end

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata) <= 16'sd29491) && ($signed(m_tdata) >= -16'sd29491))
    else $error("sample outside clamp range");

  a_muted: assert property (@(posedge clk) disable iff (rst)
    (proc_tick && !sound_enabled) |=> (m_tvalid && (m_tdata == '0)))
    else $error("muted tick produced nonzero sample");

  a_music_off: assert property (@(posedge clk) disable iff (rst)
    (proc && song_sel[2] && !cfg_wr) |=> ($stable(seq_step) && $stable(melody_phase)))
    else $error("sequencer moved with music off");

  a_mute_cancels: assert property (@(posedge clk) disable iff (rst)
    (cfg_wr && (reg_index == sts_pkg::REG_SOUND_ENABLED) && !pwdata[0])
      |=> (effect_samples_left == '0))
    else $error("mute did not cancel effect");

endmodule
